### rtl/core/gpr_pkg.sv
// Shared types, register codes and the sequencer program for the gradient palette ramp.
package gpr_pkg;

	localparam int unsigned PC_W = 4;
	localparam int unsigned N_STOP_REGS = 6;

	localparam logic [2:0] REG_STOP_COUNT = 3'd0;
	localparam logic [2:0] REG_ROTATE     = 3'd1;
	localparam logic [2:0] REG_STOP_FIRST = 3'd2;
	localparam logic [2:0] REG_STOP_LAST  = 3'd7;

	localparam logic [PC_W-1:0] STEP_WAIT = 4'd0;
	localparam logic [PC_W-1:0] STEP_LOAD = 4'd5;
	localparam logic [PC_W-1:0] STEP_EMIT = 4'd11;

	typedef enum logic [2:0] {
		OP_WAIT,
		OP_SEARCH,
		OP_LOAD,
		OP_MUL,
		OP_DIV,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		HOLD_NONE,
		HOLD_NO_REQ,
		HOLD_OUT_BUSY
	} hold_t;

	typedef enum logic [1:0] {
		BR_NEVER,
		BR_ALWAYS,
		BR_SEARCH_END
	} br_t;

	typedef struct packed {
		op_t             op;
		hold_t           hold;
		br_t             br;
		logic [PC_W-1:0] target;
	} ctl_t;

	function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
		ctl_t w;
		w = '{op: OP_WAIT, hold: HOLD_NO_REQ, br: BR_NEVER, target: STEP_WAIT};
		case (pc)
			4'd0: w = '{op: OP_WAIT,   hold: HOLD_NO_REQ,   br: BR_NEVER,      target: STEP_WAIT};
			4'd1, 4'd2, 4'd3, 4'd4:
				w = '{op: OP_SEARCH, hold: HOLD_NONE, br: BR_SEARCH_END, target: STEP_LOAD};
			4'd5: w = '{op: OP_LOAD,   hold: HOLD_NONE,     br: BR_NEVER,      target: STEP_WAIT};
			4'd6: w = '{op: OP_MUL,    hold: HOLD_NONE,     br: BR_NEVER,      target: STEP_WAIT};
			4'd7, 4'd8, 4'd9, 4'd10:
				w = '{op: OP_DIV, hold: HOLD_NONE, br: BR_NEVER, target: STEP_WAIT};
			4'd11: w = '{op: OP_EMIT,  hold: HOLD_OUT_BUSY, br: BR_ALWAYS,     target: STEP_WAIT};
			default: w = '{op: OP_WAIT, hold: HOLD_NONE,    br: BR_ALWAYS,     target: STEP_WAIT};
		endcase
		return w;
	endfunction

endpackage

### rtl/core/gradient_palette_ramp_top.sv
// Gradient palette ramp: microcoded stop search, interpolation and slot wrap.
// Steps: wait for a request, stop search (one stop per step), load, multiply, divide, emit.
// The three-lane divider retires two quotient bits per step. A new request is taken only after
//   the last result is emitted, and emit holds while the output is stalled.
// Reset: arst_n clears the sequencer and output valid and loads register defaults
//   (stop_count 2, rotate 0, stop_1 all ones, other stops zero).
module gradient_palette_ramp_top #(
	parameter int unsigned BANK_ENTRIES = 256,
	parameter int unsigned MAX_STOPS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ramp_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  palette_slot,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);
	import gpr_pkg::*;

	localparam logic [16:0] BANK_W = 17'(BANK_ENTRIES);
	localparam logic [2:0]  MAX_CNT = 3'(MAX_STOPS);

	logic [2:0]  stop_count_q;
	logic [7:0]  rotate_q;
	logic [31:0] stop_q [N_STOP_REGS];

	logic [PC_W-1:0] pc_q, pc_next;
	logic [2:0]  seg_q;
	logic        out_valid_q;
	logic [7:0]  idx_q;
	logic [8:0]  slot_q;
	logic [31:0] a_q, b_q;
	logic [7:0]  span_q, t_q;
	logic [1:0]  dk_q;
	logic [15:0] rem_q [3];
	logic [7:0]  quo_q [3];
	logic        neg_q [3];
	logic [7:0]  slot_out_q, red_q, green_q, blue_q;

	ctl_t        ctl;
	logic        hold, go, br_taken, wr;
	logic [2:0]  ridx, cnt, cnt_m2, nidx;
	logic [31:0] stop_sel;
	logic [7:0]  pa, pb, span_n, t_n;
	logic [2:0]  b1, b0;
	logic [15:0] rem_n [3];
	logic [1:0]  qb_n [3];
	logic [15:0] prod_n [3];
	logic        neg_n [3];
	logic [7:0]  val_n [3];
	logic [8:0]  slot_n;
	logic [16:0] sd1, sd0, s1_tmp;
	logic [15:0] d1, d0, r1_tmp;
	logic [8:0]  diff;
	logic [7:0]  mag, lo, hi;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign ridx = paddr[4:2];

	always_comb begin
		unique case (ridx) inside
			REG_STOP_COUNT: prdata = {29'b0, stop_count_q};
			REG_ROTATE: prdata = {24'b0, rotate_q};
			[REG_STOP_FIRST:REG_STOP_LAST]: prdata = stop_q[ridx - REG_STOP_FIRST];
			default: prdata = '0;
		endcase
	end

	// stop count clamped to 2..MAX_STOPS
	always_comb begin
		if (stop_count_q < 3'd2)
			cnt = 3'd2;
		else if (stop_count_q > MAX_CNT)
			cnt = MAX_CNT;
		else
			cnt = stop_count_q;
		cnt_m2 = cnt - 3'd2;
	end

	assign ctl = ucode(pc_q);
	assign hold = (ctl.hold == HOLD_NO_REQ && !in_valid) ||
		(ctl.hold == HOLD_OUT_BUSY && out_valid_q && out_stall);
	assign go = (seg_q < cnt_m2) && (idx_q >= b_q[31:24]);
	assign br_taken = (ctl.br == BR_ALWAYS) || (ctl.br == BR_SEARCH_END && !go);
	assign pc_next = hold ? pc_q : (br_taken ? ctl.target : pc_q + 4'd1);
	assign in_stall = (ctl.op != OP_WAIT);

	assign nidx = seg_q + 3'd2;
	always_comb begin
		stop_sel = '0;
		if (nidx < 3'(N_STOP_REGS))
			stop_sel = stop_q[nidx];
	end

	assign pa = a_q[31:24];
	assign pb = b_q[31:24];
	always_comb begin
		span_n = (pb > pa) ? pb - pa : 8'd1;
		if (idx_q < pa)
			t_n = 8'd0;
		else if (idx_q > pb)
			t_n = span_n;
		else
			t_n = idx_q - pa;
	end

	assign b1 = {dk_q, 1'b1};
	assign b0 = {dk_q, 1'b0};
	assign d1 = 16'({8'b0, span_q} << b1);
	assign d0 = 16'({8'b0, span_q} << b0);

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			lo = a_q[23 - 8*l -: 8];
			hi = b_q[23 - 8*l -: 8];
			diff = {1'b0, hi} - {1'b0, lo};
			mag = diff[8] ? 8'(-diff) : diff[7:0];
			neg_n[l] = diff[8];
			prod_n[l] = 16'(mag) * 16'(t_q);
			qb_n[l][1] = rem_q[l] >= d1;
			r1_tmp = qb_n[l][1] ? rem_q[l] - d1 : rem_q[l];
			qb_n[l][0] = r1_tmp >= d0;
			rem_n[l] = qb_n[l][0] ? r1_tmp - d0 : r1_tmp;
			val_n[l] = neg_q[l] ? lo - quo_q[l] : lo + quo_q[l];
		end
	end

	// slot reduced by BANK_ENTRIES shifted, two shifts per divide step
	always_comb begin
		sd1 = BANK_W << b1;
		sd0 = BANK_W << b0;
		s1_tmp = ({8'b0, slot_q} >= sd1) ? {8'b0, slot_q} - sd1 : {8'b0, slot_q};
		slot_n = (s1_tmp >= sd0) ? 9'(s1_tmp - sd0) : s1_tmp[8:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_WAIT;
			seg_q <= '0;
			out_valid_q <= 1'b0;
			stop_count_q <= 3'd2;
			rotate_q <= '0;
			for (int k = 0; k < N_STOP_REGS; k++)
				stop_q[k] <= (k == 1) ? 32'hFFFF_FFFF : 32'h0;
		end else begin
			pc_q <= pc_next;
			if (wr) begin
				unique case (ridx) inside
					REG_STOP_COUNT: stop_count_q <= pwdata[2:0];
					REG_ROTATE: rotate_q <= pwdata[7:0];
					[REG_STOP_FIRST:REG_STOP_LAST]: stop_q[ridx - REG_STOP_FIRST] <= pwdata;
					default: ;
				endcase
			end
			if (!hold && ctl.op == OP_EMIT)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (!hold) begin
				case (ctl.op)
					OP_WAIT: seg_q <= '0;
					OP_SEARCH: if (go) seg_q <= seg_q + 3'd1;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			case (ctl.op)
				OP_WAIT: begin
					idx_q <= ramp_index;
					slot_q <= {1'b0, ramp_index} + {1'b0, rotate_q};
					a_q <= stop_q[0];
					b_q <= stop_q[1];
				end
				OP_SEARCH: begin
					if (go) begin
						a_q <= b_q;
						b_q <= stop_sel;
					end
				end
				OP_LOAD: begin
					span_q <= span_n;
					t_q <= t_n;
				end
				OP_MUL: begin
					dk_q <= 2'd3;
					for (int l = 0; l < 3; l++) begin
						rem_q[l] <= prod_n[l];
						neg_q[l] <= neg_n[l];
						quo_q[l] <= '0;
					end
				end
				OP_DIV: begin
					dk_q <= dk_q - 2'd1;
					slot_q <= slot_n;
					for (int l = 0; l < 3; l++) begin
						rem_q[l] <= rem_n[l];
						quo_q[l] <= {quo_q[l][5:0], qb_n[l]};
					end
				end
				OP_EMIT: begin
					slot_out_q <= slot_q[7:0];
					red_q <= val_n[0];
					green_q <= val_n[1];
					blue_q <= val_n[2];
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign palette_slot = slot_out_q;
	assign red = red_q;
	assign green = green_q;
	assign blue = blue_q;

	a_accept_starts_search: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> pc_q == 4'd1)
		else $error("accepted request did not start the stop search");

	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= STEP_EMIT)
		else $error("sequencer left its program");

	a_seg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seg_q <= 3'(MAX_STOPS - 2))
		else $error("segment beyond last stop pair");

	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == OP_DIV |-> span_q != 8'd0 && rem_q[0] < {span_q, 8'b0} &&
		rem_q[1] < {span_q, 8'b0} && rem_q[2] < {span_q, 8'b0})
		else $error("divider operand out of range");

	a_emit_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == OP_EMIT && out_valid_q && out_stall |=> pc_q == STEP_EMIT)
		else $error("result emitted over a stalled result");

endmodule

### tb/gradient_palette_ramp_top_test.sv
// Testbench for gradient_palette_ramp_top: APB setup, random request/stall traffic, colour checks.
module gradient_palette_ramp_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import gpr_pkg::*;

	localparam int unsigned BANK = 256;
	localparam int unsigned STOP_MAX = 6;
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned SETTLE_CYCLES = 12;

	typedef struct packed {
		logic [7:0] slot;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} ramp_colour_t;

	class colour_ramp_tracker;
		bit [2:0]     stop_num;
		bit [7:0]     rot;
		bit [31:0]    stops [STOP_MAX];
		ramp_colour_t due_colours [$];
		int unsigned  mismatches;

		function new();
			foreach (stops[k]) stops[k] = '0;
			stops[1] = '1;
			stop_num = 3'd2;
			rot = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [2:0] reg_idx, logic [31:0] value);
			if (reg_idx == REG_STOP_COUNT) begin
				stop_num = value[2:0];
			end else if (reg_idx == REG_ROTATE) begin
				rot = value[7:0];
			end else if (reg_idx >= REG_STOP_FIRST && reg_idx <= REG_STOP_LAST) begin
				stops[reg_idx - REG_STOP_FIRST] = value;
			end
		endfunction

		function logic [7:0] blend(bit [7:0] lo_c, bit [7:0] hi_c, int t, int span);
			int lo, hi, v;
			lo = lo_c;
			hi = hi_c;
			v = lo + ((hi - lo) * t) / span;
			return v[7:0];
		endfunction

		function void note_index(logic [7:0] idx);
			int ix, count, seg, pa, pb, span, t;
			ramp_colour_t c;
			ix = idx;
			count = stop_num;
			if (count < 2) count = 2;
			if (count > STOP_MAX) count = STOP_MAX;
			seg = 0;
			while (seg + 1 < count - 1 && ix >= int'(stops[seg + 1][31:24])) seg++;
			pa = stops[seg][31:24];
			pb = stops[seg + 1][31:24];
			span = (pb > pa) ? (pb - pa) : 1;
			if (ix < pa) t = 0;
			else if (ix > pb) t = span;
			else t = ix - pa;
			c.slot = 8'((ix + int'(rot)) % BANK);
			c.r = blend(stops[seg][23:16], stops[seg + 1][23:16], t, span);
			c.g = blend(stops[seg][15:8], stops[seg + 1][15:8], t, span);
			c.b = blend(stops[seg][7:0], stops[seg + 1][7:0], t, span);
			due_colours.push_back(c);
		endfunction

		function void check_colour(ramp_colour_t got);
			ramp_colour_t want;
			if (due_colours.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result slot=%0h rgb=%0h %0h %0h",
						$realtime, got.slot, got.r, got.g, got.b);
				return;
			end
			want = due_colours.pop_front();
			if (got.slot !== want.slot || got.r !== want.r || got.g !== want.g
					|| got.b !== want.b) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch slot/r/g/b expected %0h %0h %0h %0h got %0h %0h %0h %0h",
						$realtime, want.slot, want.r, want.g, want.b,
						got.slot, got.r, got.g, got.b);
			end
		endfunction

		function int unsigned pending();
			return due_colours.size();
		endfunction

		function bit failed();
			return mismatches != 0 || due_colours.size() != 0;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  ramp_index;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  palette_slot;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;

	colour_ramp_tracker tracker;
	int unsigned quiet_cycles;
	bit          steady_feed;
	bit [31:0]   plan [STOP_MAX];

	gradient_palette_ramp_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.ramp_index   (ramp_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.palette_slot (palette_slot),
		.red          (red),
		.green        (green),
		.blue         (blue)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned pause_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	task automatic apb_write(input logic [2:0] reg_idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		tracker.write_reg(reg_idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_index(input logic [7:0] idx);
		int unsigned gap;
		gap = steady_feed ? 0 : pause_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		ramp_index <= idx;
		@(posedge clk);
		while (!(in_valid && !in_stall)) @(posedge clk);
	endtask

	// lower valid and let the block drain before touching registers
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_ramp(input logic [2:0] count, input logic [7:0] rot_val);
		apb_write(REG_STOP_COUNT, {29'd0, count});
		apb_write(REG_ROTATE, {24'd0, rot_val});
		for (int k = 0; k < STOP_MAX; k++) apb_write(REG_STOP_FIRST + 3'(k), plan[k]);
	endtask

	function automatic logic [7:0] pick_byte();
		int unsigned r;
		r = $urandom_range(0, 7);
		if (r == 0) return 8'h00;
		if (r == 1) return 8'hff;
		return 8'($urandom);
	endfunction

	task automatic random_ramp();
		int p;
		logic [7:0] rot_val;
		bit ordered;
		ordered = $urandom_range(0, 3) != 0;
		p = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
		for (int k = 0; k < STOP_MAX; k++) begin
			if (!ordered) p = $urandom_range(0, 255);
			else if (k > 0) p = p + $urandom_range(0, 70);
			if (p > 255) p = 255;
			plan[k] = {8'(p), pick_byte(), pick_byte(), pick_byte()};
		end
		case ($urandom_range(0, 3))
			0: rot_val = 8'h00;
			1: rot_val = 8'hff;
			default: rot_val = 8'($urandom);
		endcase
		load_ramp(3'($urandom_range(0, 7)), rot_val);
	endtask

	function automatic logic [7:0] pick_index();
		int unsigned k;
		if ($urandom_range(0, 3) != 0) return 8'($urandom);
		k = $urandom_range(0, STOP_MAX - 1);
		return tracker.stops[k][31:24] + 8'($urandom_range(0, 2)) - 8'd1;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) tracker.note_index(ramp_index);
			if (out_valid && !out_stall) tracker.check_colour({palette_slot, red, green, blue});
			if ((in_valid && !in_stall) || (out_valid && !out_stall)
					|| (psel && penable && pwrite && pready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("gradient_palette_ramp_top test failed");
					$finish;
				end
			end
		end
	end

	initial begin : out_side
		int unsigned busy;
		int unsigned free;
		busy = 0;
		free = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (busy != 0) begin
				out_stall <= 1'b1;
				busy--;
			end else begin
				out_stall <= 1'b0;
				if (free != 0) begin
					free--;
				end else begin
					free = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
						: $urandom_range(0, 6);
					busy = pause_len();
				end
			end
		end
	end

	initial begin
		tracker = new();
		quiet_cycles = 0;
		steady_feed = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		ramp_index = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// reset ramp: black at 0 to white at 255
		send_index(8'd0);
		send_index(8'd1);
		send_index(8'd127);
		send_index(8'd128);
		send_index(8'd254);
		send_index(8'd255);
		send_index(8'h55);
		send_index(8'haa);
		settle();

		// count below two, rotation 255, both stops at one position
		apb_write(REG_STOP_COUNT, 32'd0);
		apb_write(REG_ROTATE, 32'd255);
		apb_write(REG_STOP_FIRST, 32'h4010_80f0);
		apb_write(REG_STOP_FIRST + 3'd1, 32'h40f0_2000);
		send_index(8'd0);
		send_index(8'd63);
		send_index(8'd64);
		send_index(8'd65);
		send_index(8'd255);
		settle();

		// count above six, repeated and falling positions
		plan[0] = 32'h00ff_00ff;
		plan[1] = 32'h2800_ff00;
		plan[2] = 32'h28ff_ffff;
		plan[3] = 32'h6400_0000;
		plan[4] = 32'h5a80_40c0;
		plan[5] = 32'hfa12_34ff;
		load_ramp(3'd7, 8'd1);
		send_index(8'd0);
		send_index(8'd39);
		send_index(8'd40);
		send_index(8'd41);
		send_index(8'd95);
		send_index(8'd100);
		send_index(8'd200);
		send_index(8'd255);
		settle();

		for (int phase = 0; phase < 13; phase++) begin
			random_ramp();
			steady_feed = (phase % 4) == 1;
			for (int n = 0; n < 150; n++) send_index(pick_index());
			settle();
		end

		while (tracker.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.failed()) begin
			$display("gradient_palette_ramp_top test failed");
		end else begin
			$display("gradient_palette_ramp_top test passed");
		end
		$finish;
	end
endmodule

### sim.f
rtl/core/gpr_pkg.sv
rtl/core/gradient_palette_ramp_top.sv
tb/gradient_palette_ramp_top_test.sv
